[sv/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Command and status codes, the per-cell control group and the default sizes.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH_DEFAULT       = 16;
	localparam int VALUE_WIDTH_DEFAULT = 32;

	// Field widths fixed by the interface
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 5;
	localparam int COUNT_W  = 5;
	localparam int RESULT_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_PEEK   = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// Control broadcast to every cell of the chain
	typedef struct packed {
		logic insert;
		logic remove;
	} cell_ctrl_t;

endpackage

[sv/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry, compares it with the incoming value and takes its own new
// value from the left neighbour, the right neighbour or the incoming value.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
	input  logic                          clk,
	input  cell_ctrl_t                    ctrl,
	input  logic signed [VALUE_WIDTH-1:0] new_value,
	input  logic                          occupied,
	input  logic                          prev_pos,
	input  logic signed [VALUE_WIDTH-1:0] left_value,
	input  logic signed [VALUE_WIDTH-1:0] right_value,
	output logic signed [VALUE_WIDTH-1:0] value,
	output logic                          pos
);

	logic signed [VALUE_WIDTH-1:0] value_q;

	// New value belongs at or before this slot: slot empty or strictly greater
	assign pos   = !occupied || (value_q > new_value);
	assign value = value_q;

	// Shift right on insert behind the insertion point, shift left on remove
	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (pos) begin
				value_q <= prev_pos ? left_value : new_value;
			end
		end else if (ctrl.remove) begin
			value_q <= right_value;
		end
	end

endmodule

[sv/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded min-priority queue in a chain of sorted cells
// Insert, remove-smallest and peek-smallest with full and empty status.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall with command and item_value; each
//   request gives exactly one response on out_valid/out_stall carrying
//   result_value, status and entry_count (count after the request).
//   Every cell compares its entry with the incoming value and shifts in the
//   same cycle; the response appears in the output register in the cycle
//   after acceptance, and one request per cycle is taken while the output is
//   drained.
//   When the receiver stalls, the response holds in the output register and
//   in_stall rises until it is taken; no request is lost.
//   Equal values leave in arrival order. Insert into a full queue answers
//   status full; remove or peek on an empty queue answers status empty and
//   value -1. Command 3 answers value 0, status ok and the current count.
//   capacity_limit is written through cfg_write_en/cfg_write_data; the user
//   writes it only while idle, unenforced; values above DEPTH count as DEPTH.
//   Reset empties the queue at once (count to zero, capacity to 16); there
//   is no clearing pass, and the cell contents are left as they are.
// ----------------------------------------------------------------------------
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEFAULT,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write_en,
	input  logic [CAP_W-1:0]           cfg_write_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [CMD_W-1:0]           command,
	input  logic signed [RESULT_W-1:0] item_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [RESULT_W-1:0] result_value,
	output logic [STATUS_W-1:0]        status,
	output logic [COUNT_W-1:0]         entry_count
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = CNT_W + CAP_W;

	logic [CAP_W-1:0]              cap_q;
	logic [CNT_W-1:0]              count_q;
	logic                          out_valid_q;
	logic signed [RESULT_W-1:0]    result_q;
	status_t                       status_q;
	logic [COUNT_W-1:0]            entry_count_q;

	logic                          accept;
	logic                          full;
	logic                          empty;
	logic signed [VALUE_WIDTH-1:0] new_value;
	logic signed [VALUE_WIDTH-1:0] cell_value [DEPTH];
	logic [DEPTH-1:0]              cell_pos;
	cell_ctrl_t                    ctrl;
	logic [CNT_W-1:0]              count_d;
	logic signed [RESULT_W-1:0]    result_d;
	status_t                       status_d;

	// Input side waits only while a response is held
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign new_value = VALUE_WIDTH'(item_value);

	assign full  = (CMP_W'(count_q) >= CMP_W'(cap_q)) || (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// Decode the request into cell control, response and next count
	always_comb begin
		ctrl     = '0;
		count_d  = count_q;
		result_d = '0;
		status_d = STATUS_OK;
		unique case (command)
			CMD_INSERT: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					ctrl.insert = accept;
					count_d     = count_q + 1'b1;
				end
			end
			CMD_REMOVE, CMD_PEEK: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
					result_d = '1;
				end else begin
					result_d = RESULT_W'(cell_value[0]);
					if (command == CMD_REMOVE) begin
						ctrl.remove = accept;
						count_d     = count_q - 1'b1;
					end
				end
			end
			default: begin
				result_d = '0;
			end
		endcase
	end

	// Chain of cells, each seeing both neighbours
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                          prev_pos;
		logic signed [VALUE_WIDTH-1:0] left_value;
		logic signed [VALUE_WIDTH-1:0] right_value;

		if (i == 0) begin : g_first
			assign prev_pos   = 1'b0;
			assign left_value = new_value;
		end else begin : g_inner
			assign prev_pos   = cell_pos[i-1];
			assign left_value = cell_value[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_value = cell_value[i];
		end else begin : g_body
			assign right_value = cell_value[i+1];
		end

		spq_cell #(
			.VALUE_WIDTH (VALUE_WIDTH)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.new_value   (new_value),
			.occupied    (CNT_W'(i) < count_q),
			.prev_pos    (prev_pos),
			.left_value  (left_value),
			.right_value (right_value),
			.value       (cell_value[i]),
			.pos         (cell_pos[i])
		);
	end

	// Hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_write_en) begin
			cap_q <= cfg_write_data;
		end
	end

	// Advance the count and the response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q      <= result_d;
			status_q      <= status_d;
			entry_count_q <= COUNT_W'(count_d);
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign status       = status_q;
	assign entry_count  = entry_count_q;

	// Count never exceeds the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// A granted insert grows the count by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == CMD_INSERT && !full |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the count");

	// An empty response carries all ones
	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_EMPTY |-> result_value == '1)
		else $error("empty response without all-ones value");

	// Every accepted request shows a response next cycle
	a_response: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted request gave no response");

endmodule
